[design/gjc_pkg.sv]
`default_nettype none
package gjc_pkg;

   localparam int MaxJoints = 8;
   localparam int LimitRaw  = (MaxJoints < 8) ? MaxJoints : 8;
   localparam logic [3:0] ColLimit = 4'(LimitRaw - 1);

   localparam logic OpTool  = 1'b0;
   localparam logic OpJoint = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_MAT,
      ST_ROW,
      ST_DIV,
      ST_DIVEND,
      ST_CROSS,
      ST_LIN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[design/gjc_divider.sv]
`default_nettype none
// Restoring divider: magnitude quotient of num / den, one bit per cycle.
module gjc_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [33:0] den,
   output logic             busy,
   output logic [63:0]      quot
);
   import gjc_pkg::*;

   logic [6:0]  count_ff, count_in;
   logic [34:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [33:0] den_ff, den_in;
   logic [34:0] trial;

   always_comb begin
      count_in = count_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      den_in   = den_ff;
      trial    = {rem_ff[33:0], q_ff[63]} - {1'b0, den_ff};
      if (start) begin
         count_in = 7'd64;
         rem_in   = '0;
         q_in     = num;
         den_in   = den;
      end else if (count_ff != 7'd0) begin
         count_in = count_ff - 7'd1;
         if (!trial[34]) begin
            rem_in = trial;
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[33:0], q_ff[63]};
            q_in   = {q_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign busy = (count_ff != 7'd0);
   assign quot = q_ff;
endmodule
`default_nettype wire

[design/geometric_jacobian_columns_core.sv]
`default_nettype none
// Sequence: an end-effector request is taken while idle and gives no result. A joint
// request passes through the rotation matrix and three passes of the shared bit-serial
// divider; a revolute one then forms the cross product, a prismatic one skips it.
// Flow: one joint request at a time, the next taken once the sequencer is idle again after
// the column has moved to the output register; a waiting column holds the sequencer.
// Reset: synchronous, active high; clears the tool position, column counter and
// sequencer, and drops the result valid.
module geometric_jacobian_columns_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic signed [15:0] req_rot_w,
   input  wire logic signed [15:0] req_rot_x,
   input  wire logic signed [15:0] req_rot_y,
   input  wire logic signed [15:0] req_rot_z,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [15:0] req_axis_x,
   input  wire logic signed [15:0] req_axis_y,
   input  wire logic signed [15:0] req_axis_z,
   input  wire logic               req_is_prismatic,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_column_index,
   output logic signed [31:0]      rsp_lin_x,
   output logic signed [31:0]      rsp_lin_y,
   output logic signed [31:0]      rsp_lin_z,
   output logic signed [15:0]      rsp_ang_x,
   output logic signed [15:0]      rsp_ang_y,
   output logic signed [15:0]      rsp_ang_z,
   output logic                    rsp_index_overflow
);
   import gjc_pkg::*;

   // The sequencer computes the nine scaled rotation-matrix entries with one
   // shared 17x17 multiplier, then for each base-frame axis row forms the dot
   // product with the joint axis and divides by the squared norm. Finally the
   // cross product with the lever arm uses a shared 16x33 multiplier.
   // A finished column is copied into its own output register, so the input
   // side is free again while the column waits to be taken.

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] row_ff, row_in;

   logic signed [31:0] tool_ff [3];
   logic [3:0]         cnt_ff, cnt_in;

   logic signed [15:0] q_ff [4];
   logic signed [15:0] a_ff [3];
   logic signed [32:0] r_ff [3];
   logic               pris_ff;

   logic signed [31:0] sq_ff [10];  // products of quaternion pairs
   logic signed [35:0] m_ff [9];
   logic signed [54:0] acc_ff, acc_in;
   logic [33:0]        n2_ff;
   logic signed [15:0] z_ff [3];
   logic signed [51:0] prod_ff;
   logic signed [52:0] lin_acc_ff;
   logic signed [31:0] lin_ff [3];

   logic               rsp_valid_ff;
   logic [2:0]         idx_ff;
   logic               ovf_ff;
   logic signed [31:0] col_lin_ff [3];
   logic signed [15:0] col_ang_ff [3];

   logic take;
   logic rsp_free;
   assign take      = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   // The output register can take a new column when it is empty or being emptied.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Shared small multiplier.
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] mul_p;
   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         5'd0: begin mul_a = 17'(q_ff[0]); mul_b = 17'(q_ff[0]); end
         5'd1: begin mul_a = 17'(q_ff[1]); mul_b = 17'(q_ff[1]); end
         5'd2: begin mul_a = 17'(q_ff[2]); mul_b = 17'(q_ff[2]); end
         5'd3: begin mul_a = 17'(q_ff[3]); mul_b = 17'(q_ff[3]); end
         5'd4: begin mul_a = 17'(q_ff[1]); mul_b = 17'(q_ff[2]); end
         5'd5: begin mul_a = 17'(q_ff[0]); mul_b = 17'(q_ff[3]); end
         5'd6: begin mul_a = 17'(q_ff[1]); mul_b = 17'(q_ff[3]); end
         5'd7: begin mul_a = 17'(q_ff[0]); mul_b = 17'(q_ff[2]); end
         5'd8: begin mul_a = 17'(q_ff[2]); mul_b = 17'(q_ff[3]); end
         5'd9: begin mul_a = 17'(q_ff[0]); mul_b = 17'(q_ff[1]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Dot product term: m[row][step] * a[step].
   logic signed [35:0] dot_m;
   logic signed [15:0] dot_a;
   logic signed [51:0] dot_p;
   always_comb begin
      dot_m = m_ff[0];
      dot_a = a_ff[0];
      case (step_ff)
         5'd0: dot_a = a_ff[0];
         5'd1: dot_a = a_ff[1];
         5'd2: dot_a = a_ff[2];
         default: dot_a = a_ff[0];
      endcase
      case ({row_ff, step_ff[1:0]})
         4'b0000: dot_m = m_ff[0];
         4'b0001: dot_m = m_ff[1];
         4'b0010: dot_m = m_ff[2];
         4'b0100: dot_m = m_ff[3];
         4'b0101: dot_m = m_ff[4];
         4'b0110: dot_m = m_ff[5];
         4'b1000: dot_m = m_ff[6];
         4'b1001: dot_m = m_ff[7];
         4'b1010: dot_m = m_ff[8];
         default: dot_m = m_ff[0];
      endcase
   end
   assign dot_p = dot_m * dot_a;

   // Divider.
   logic        div_start, div_busy;
   logic [63:0] div_num, div_quot;
   logic        acc_neg;
   logic [54:0] acc_mag;
   assign acc_neg = acc_ff[54];
   assign acc_mag = acc_neg ? 55'(-acc_ff) : 55'(acc_ff);
   // (2|s| + n2) / (2 n2) == (|s| + n2/2 rounded) / n2 handled by doubling.
   assign div_num = 64'({acc_mag, 1'b0}) + 64'(n2_ff);

   gjc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (n2_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Divisor must be 2*n2: shift the quotient by one instead.
   logic [62:0] qmag;
   logic signed [15:0] z_sat;
   assign qmag = div_quot[63:1];
   always_comb begin
      if (n2_ff == '0) begin
         z_sat = '0;
      end else if (!acc_neg) begin
         z_sat = (qmag > 63'd32767) ? 16'sd32767 : 16'(qmag);
      end else begin
         z_sat = (qmag > 63'd32768) ? -16'sd32768 : 16'(-qmag);
      end
   end

   // Cross product: lin[k] = z[a]*r[b] - z[b]*r[a].
   logic signed [15:0] cz;
   logic signed [32:0] cr;
   logic signed [49:0] cp;
   always_comb begin
      cz = z_ff[1];
      cr = r_ff[2];
      case ({row_ff, step_ff[0]})
         3'b000: begin cz = z_ff[1]; cr = r_ff[2]; end
         3'b001: begin cz = z_ff[2]; cr = r_ff[1]; end
         3'b010: begin cz = z_ff[2]; cr = r_ff[0]; end
         3'b011: begin cz = z_ff[0]; cr = r_ff[2]; end
         3'b100: begin cz = z_ff[0]; cr = r_ff[1]; end
         3'b101: begin cz = z_ff[1]; cr = r_ff[0]; end
         default: begin cz = z_ff[1]; cr = r_ff[2]; end
      endcase
   end
   assign cp = cz * cr;

   // Round Q30 to Q16.16 half away from zero, then saturate.
   logic        l_neg;
   logic [52:0] l_mag;
   logic [38:0] l_q;
   logic signed [31:0] l_sat;
   assign l_neg = lin_acc_ff[52];
   assign l_mag = l_neg ? 53'(-lin_acc_ff) : 53'(lin_acc_ff);
   assign l_q   = 39'((l_mag + 53'd8192) >> 14);
   always_comb begin
      if (!l_neg) begin
         l_sat = (l_q > 39'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(l_q);
      end else begin
         l_sat = (l_q > 39'h80000000) ? 32'sh80000000 : 32'(-l_q);
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (take && req_operation == OpJoint) state_in = ST_SQ;
         ST_SQ:     if (step_ff == 5'd9) state_in = ST_MAT;
         ST_MAT:    state_in = ST_ROW;
         ST_ROW:    if (step_ff == 5'd2) state_in = ST_DIV;
         ST_DIV:    state_in = ST_DIVEND;
         ST_DIVEND: if (!div_busy) begin
               if (row_ff == 2'd2) state_in = pris_ff ? ST_DONE : ST_CROSS;
               else state_in = ST_ROW;
            end
         ST_CROSS:  if (step_ff == 5'd1) state_in = ST_LIN;
         ST_LIN:    state_in = (row_ff == 2'd2) ? ST_DONE : ST_CROSS;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Output and datapath control.
   always_comb begin
      step_in   = step_ff;
      row_in    = row_ff;
      acc_in    = acc_ff;
      div_start = 1'b0;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            row_in  = '0;
            if (take) begin
               if (req_operation == OpTool) cnt_in = '0;
            end
         end
         ST_SQ:  step_in = (step_ff == 5'd9) ? 5'd0 : step_ff + 5'd1;
         ST_MAT: begin
            step_in = '0;
            acc_in  = '0;
         end
         ST_ROW: begin
            acc_in  = acc_ff + 55'(dot_p);
            step_in = (step_ff == 5'd2) ? 5'd0 : step_ff + 5'd1;
         end
         ST_DIV: div_start = 1'b1;
         ST_DIVEND: if (!div_busy) begin
               acc_in = '0;
               row_in = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
            end
         ST_CROSS: step_in = (step_ff == 5'd1) ? 5'd0 : step_ff + 5'd1;
         ST_LIN: row_in = row_ff + 2'd1;
         ST_DONE: if (rsp_free && cnt_ff != 4'd15) cnt_in = cnt_ff + 4'd1;
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) tool_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (take && req_operation == OpTool) begin
            tool_ff[0] <= req_pos_x;
            tool_ff[1] <= req_pos_y;
            tool_ff[2] <= req_pos_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (take) begin
         q_ff[0] <= req_rot_w;
         q_ff[1] <= req_rot_x;
         q_ff[2] <= req_rot_y;
         q_ff[3] <= req_rot_z;
         a_ff[0] <= req_axis_x;
         a_ff[1] <= req_axis_y;
         a_ff[2] <= req_axis_z;
         pris_ff <= req_is_prismatic;
         r_ff[0] <= 33'(tool_ff[0]) - 33'(req_pos_x);
         r_ff[1] <= 33'(tool_ff[1]) - 33'(req_pos_y);
         r_ff[2] <= 33'(tool_ff[2]) - 33'(req_pos_z);
      end
      if (state_ff == ST_SQ) sq_ff[step_ff[3:0]] <= 32'(mul_p);
      if (state_ff == ST_MAT) begin
         n2_ff   <= 34'(36'(sq_ff[0]) + 36'(sq_ff[1]) + 36'(sq_ff[2]) + 36'(sq_ff[3]));
         m_ff[0] <= 36'(sq_ff[0]) + 36'(sq_ff[1]) - 36'(sq_ff[2]) - 36'(sq_ff[3]);
         m_ff[4] <= 36'(sq_ff[0]) - 36'(sq_ff[1]) + 36'(sq_ff[2]) - 36'(sq_ff[3]);
         m_ff[8] <= 36'(sq_ff[0]) - 36'(sq_ff[1]) - 36'(sq_ff[2]) + 36'(sq_ff[3]);
         m_ff[1] <= (36'(sq_ff[4]) - 36'(sq_ff[5])) <<< 1;
         m_ff[3] <= (36'(sq_ff[4]) + 36'(sq_ff[5])) <<< 1;
         m_ff[2] <= (36'(sq_ff[6]) + 36'(sq_ff[7])) <<< 1;
         m_ff[6] <= (36'(sq_ff[6]) - 36'(sq_ff[7])) <<< 1;
         m_ff[5] <= (36'(sq_ff[8]) - 36'(sq_ff[9])) <<< 1;
         m_ff[7] <= (36'(sq_ff[8]) + 36'(sq_ff[9])) <<< 1;
      end
      if (state_ff == ST_DIVEND && !div_busy) z_ff[row_ff] <= z_sat;
      if (state_ff == ST_CROSS) begin
         if (step_ff == 5'd0) prod_ff <= 52'(cp);
         else lin_acc_ff <= 53'(prod_ff) - 53'(cp);
      end
      if (state_ff == ST_LIN) lin_ff[row_ff] <= l_sat;
      // A prismatic column is the rotated axis in Q16.16 with no angular part.
      if (state_ff == ST_DONE && rsp_free) begin
         idx_ff <= (cnt_ff > ColLimit) ? ColLimit[2:0] : cnt_ff[2:0];
         ovf_ff <= (cnt_ff > ColLimit);
         for (int k = 0; k < 3; k++) begin
            col_lin_ff[k] <= pris_ff ? (32'(z_ff[k]) <<< 2) : lin_ff[k];
            col_ang_ff[k] <= pris_ff ? 16'sd0 : z_ff[k];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_index   = idx_ff;
   assign rsp_lin_x          = col_lin_ff[0];
   assign rsp_lin_y          = col_lin_ff[1];
   assign rsp_lin_z          = col_lin_ff[2];
   assign rsp_ang_x          = col_ang_ff[0];
   assign rsp_ang_y          = col_ang_ff[1];
   assign rsp_ang_z          = col_ang_ff[2];
   assign rsp_index_overflow = ovf_ff;
endmodule
`default_nettype wire
